FILE: src/dfs_reachability_tree_edges_defines.svh
// Assertion macros for the DFS block.
`ifndef DFS_REACHABILITY_TREE_EDGES_DEFINES_SVH
`define DFS_REACHABILITY_TREE_EDGES_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define DFSRT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dfsrt assertion failed");
// next-cycle implication
`define DFSRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dfsrt assertion failed");
`else
`define DFSRT_ASSERT_NOW(lbl, ante, cons)
`define DFSRT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: src/dfsrt_pkg.sv
package dfsrt_pkg;

  localparam int VERT_BITS        = 16;  // reached mask / row width
  localparam int VID_W            = 4;   // vertex id width
  localparam int CNT_W            = 5;   // count / vertex_count width
  localparam int LANE_W           = 4;   // vertices per lane
  localparam int NUM_LANES        = VERT_BITS / LANE_W;
  localparam int LANE_IW          = $clog2(LANE_W);
  localparam int STACK_DEPTH      = 16;
  localparam int MAX_VERTICES_DEF = 16;
  localparam logic [CNT_W-1:0] VC_RESET = 5'd16;

  localparam logic ACT_LOAD     = 1'b0;
  localparam logic ACT_START    = 1'b1;
  localparam logic KIND_EDGE    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic               hit;
    logic [LANE_IW-1:0] idx;
  } lane_res_t;

endpackage

FILE: src/dfs_reachability_tree_edges.sv
// Load item (in_action 0): row stored at the accepting edge, no result, busy stays low.
// Start item: one step per cycle (push on a new tree edge, pop on a dead end), with
// busy high until the final pop; each edge shows in the cycle after its step.
// The summary shows the cycle after the final pop; a bad source gives it the cycle after start.
// Busy holds off further items: a new start item is accepted only after the search has ended.
// rst_n (sync, active low) clears marks, stack depth, state, strobe; vertex_count goes to 16.
`include "dfs_reachability_tree_edges_defines.svh"

module dfs_reachability_tree_edges #(
  parameter int MAX_VERTICES = dfsrt_pkg::MAX_VERTICES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_wr_en,
  input  logic [dfsrt_pkg::CNT_W-1:0]       cfg_wr_data,
  // input item channel
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_action,
  input  logic [dfsrt_pkg::VID_W-1:0]       in_row_index,
  input  logic [dfsrt_pkg::VERT_BITS-1:0]   in_row_bits,
  input  logic [dfsrt_pkg::VID_W-1:0]       in_source_vertex,
  // result channel, one-cycle strobe
  output logic                              out_valid,
  output logic                              out_item_kind,
  output logic [dfsrt_pkg::VID_W-1:0]       out_edge_from,
  output logic [dfsrt_pkg::VID_W-1:0]       out_edge_to,
  output logic [dfsrt_pkg::VERT_BITS-1:0]   out_reached_mask,
  output logic [dfsrt_pkg::CNT_W-1:0]       out_reached_count,
  output logic                              out_all_reached,
  output logic                              out_bad_source,
  output logic                              out_last
);

  // Rows actually stored; vertices above 16 do not fit the 4-bit ids.
  localparam int ROWS   = (MAX_VERTICES < dfsrt_pkg::VERT_BITS) ? MAX_VERTICES
                                                                 : dfsrt_pkg::VERT_BITS;
  localparam int ROW_AW = $clog2(ROWS);
  localparam int SP_W   = $clog2(dfsrt_pkg::STACK_DEPTH);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_SEARCH = 1'b1;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  logic [dfsrt_pkg::CNT_W-1:0]     vc_r;
  logic                            state_r, state_nxt;
  logic [dfsrt_pkg::CNT_W-1:0]     depth_r, depth_nxt;
  logic [dfsrt_pkg::VERT_BITS-1:0] reached_r, reached_nxt;
  logic [dfsrt_pkg::CNT_W-1:0]     count_r, count_nxt;

  logic [dfsrt_pkg::VERT_BITS-1:0] rows_r  [ROWS];
  logic [dfsrt_pkg::VID_W-1:0]     stack_r [dfsrt_pkg::STACK_DEPTH];

  // output register
  logic                            ov_r, ov_nxt;
  logic                            okind_r, okind_nxt;
  logic [dfsrt_pkg::VID_W-1:0]     ofrom_r, ofrom_nxt;
  logic [dfsrt_pkg::VID_W-1:0]     oto_r, oto_nxt;
  logic [dfsrt_pkg::VERT_BITS-1:0] omask_r, omask_nxt;
  logic [dfsrt_pkg::CNT_W-1:0]     ocount_r, ocount_nxt;
  logic                            oall_r, oall_nxt;
  logic                            obad_r, obad_nxt;
  logic                            olast_r, olast_nxt;

  // ---------------------------------------------------------------------------
  // Vertices in use: vertex_count saturated to the storable row count
  // ---------------------------------------------------------------------------
  logic [dfsrt_pkg::CNT_W-1:0]     n_use;
  logic [dfsrt_pkg::VERT_BITS-1:0] in_use;

  assign n_use = (vc_r > dfsrt_pkg::CNT_W'(ROWS)) ? dfsrt_pkg::CNT_W'(ROWS) : vc_r;

  always_comb begin
    for (int i = 0; i < dfsrt_pkg::VERT_BITS; i++) begin
      in_use[i] = (dfsrt_pkg::CNT_W'(i) < n_use);
    end
  end

  logic accept, do_load, do_start, src_bad;

  assign busy     = (state_r == ST_SEARCH);
  assign accept   = start && !busy;
  assign do_load  = accept && (in_action == dfsrt_pkg::ACT_LOAD);
  assign do_start = accept && (in_action == dfsrt_pkg::ACT_START);
  assign src_bad  = ({1'b0, in_source_vertex} >= n_use);

  // ---------------------------------------------------------------------------
  // Stack top and its row, fanned out to the lanes
  // ---------------------------------------------------------------------------
  logic [SP_W-1:0]                 top_idx;
  logic [dfsrt_pkg::VID_W-1:0]     top_v;
  logic [dfsrt_pkg::VERT_BITS-1:0] top_row;

  assign top_idx = SP_W'(depth_r - 1'b1);
  assign top_v   = stack_r[top_idx];
  assign top_row = rows_r[top_v[ROW_AW-1:0]];

  dfsrt_pkg::lane_res_t lane_res [dfsrt_pkg::NUM_LANES];

  for (genvar l = 0; l < dfsrt_pkg::NUM_LANES; l++) begin : g_lane
    dfsrt_lane u_lane (
      .row_bits  (top_row  [l*dfsrt_pkg::LANE_W +: dfsrt_pkg::LANE_W]),
      .use_bits  (in_use   [l*dfsrt_pkg::LANE_W +: dfsrt_pkg::LANE_W]),
      .seen_bits (reached_r[l*dfsrt_pkg::LANE_W +: dfsrt_pkg::LANE_W]),
      .res       (lane_res[l])
    );
  end

  logic                        nb_found;
  logic [dfsrt_pkg::VID_W-1:0] nb_vertex;

  dfsrt_merge u_merge (
    .lanes  (lane_res),
    .found  (nb_found),
    .vertex (nb_vertex)
  );

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt   = state_r;
    depth_nxt   = depth_r;
    reached_nxt = reached_r;
    count_nxt   = count_r;

    ov_nxt      = 1'b0;
    okind_nxt   = dfsrt_pkg::KIND_EDGE;
    ofrom_nxt   = '0;
    oto_nxt     = '0;
    omask_nxt   = '0;
    ocount_nxt  = '0;
    oall_nxt    = 1'b0;
    obad_nxt    = 1'b0;
    olast_nxt   = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (do_start) begin
          if (src_bad) begin
            // marks cleared, lone bad-source summary
            reached_nxt = '0;
            count_nxt   = '0;
            depth_nxt   = '0;
            ov_nxt      = 1'b1;
            okind_nxt   = dfsrt_pkg::KIND_SUMMARY;
            obad_nxt    = 1'b1;
            olast_nxt   = 1'b1;
          end else begin
            reached_nxt = dfsrt_pkg::VERT_BITS'(1) << in_source_vertex;
            count_nxt   = dfsrt_pkg::CNT_W'(1);
            depth_nxt   = dfsrt_pkg::CNT_W'(1);
            state_nxt   = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (nb_found) begin
          // push: new tree edge
          reached_nxt = reached_r | (dfsrt_pkg::VERT_BITS'(1) << nb_vertex);
          count_nxt   = count_r + 1'b1;
          depth_nxt   = depth_r + 1'b1;
          ov_nxt      = 1'b1;
          ofrom_nxt   = top_v;
          oto_nxt     = nb_vertex;
        end else begin
          // pop; emptying the stack ends the run with the summary
          depth_nxt = depth_r - 1'b1;
          if (depth_r == dfsrt_pkg::CNT_W'(1)) begin
            state_nxt  = ST_IDLE;
            ov_nxt     = 1'b1;
            okind_nxt  = dfsrt_pkg::KIND_SUMMARY;
            omask_nxt  = reached_r;
            ocount_nxt = count_r;
            oall_nxt   = (count_r == n_use);
            olast_nxt  = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r      <= dfsrt_pkg::VC_RESET;
      state_r   <= ST_IDLE;
      depth_r   <= '0;
      reached_r <= '0;
      count_r   <= '0;
      ov_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        vc_r <= cfg_wr_data;
      end
      state_r   <= state_nxt;
      depth_r   <= depth_nxt;
      reached_r <= reached_nxt;
      count_r   <= count_nxt;
      ov_r      <= ov_nxt;
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    okind_r  <= okind_nxt;
    ofrom_r  <= ofrom_nxt;
    oto_r    <= oto_nxt;
    omask_r  <= omask_nxt;
    ocount_r <= ocount_nxt;
    oall_r   <= oall_nxt;
    obad_r   <= obad_nxt;
    olast_r  <= olast_nxt;
  end

  // adjacency rows; indexes at or above the row count are dropped
  always_ff @(posedge clk) begin
    if (do_load && ({1'b0, in_row_index} < dfsrt_pkg::CNT_W'(ROWS))) begin
      rows_r[in_row_index[ROW_AW-1:0]] <= in_row_bits;
    end
  end

  // path stack
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      if (do_start && !src_bad) begin
        stack_r[0] <= in_source_vertex;
      end
    end else if (nb_found) begin
      stack_r[depth_r[SP_W-1:0]] <= nb_vertex;
    end
  end

  assign out_valid         = ov_r;
  assign out_item_kind     = okind_r;
  assign out_edge_from     = ofrom_r;
  assign out_edge_to       = oto_r;
  assign out_reached_mask  = omask_r;
  assign out_reached_count = ocount_r;
  assign out_all_reached   = oall_r;
  assign out_bad_source    = obad_r;
  assign out_last          = olast_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `DFSRT_ASSERT_NEXT(a_bad_src_summary, do_start && src_bad, out_valid && out_bad_source && out_last)
  `DFSRT_ASSERT_NOW(a_search_stack_nonempty, state_r == ST_SEARCH, depth_r != '0)
  `DFSRT_ASSERT_NOW(a_edge_mid_search, out_valid && (out_item_kind == dfsrt_pkg::KIND_EDGE), busy)
  `DFSRT_ASSERT_NOW(a_count_matches_marks, 1'b1, count_r == $countones(reached_r))

endmodule

FILE: src/dfsrt_lane.sv
// One lane: first open vertex within its slice.
module dfsrt_lane (
  input  logic [dfsrt_pkg::LANE_W-1:0] row_bits,
  input  logic [dfsrt_pkg::LANE_W-1:0] use_bits,
  input  logic [dfsrt_pkg::LANE_W-1:0] seen_bits,
  output dfsrt_pkg::lane_res_t         res
);

  logic [dfsrt_pkg::LANE_W-1:0] open_bits;

  assign open_bits = row_bits & use_bits & ~seen_bits;

  always_comb begin
    res.hit = |open_bits;
    res.idx = '0;
    for (int i = dfsrt_pkg::LANE_W - 1; i >= 0; i--) begin
      if (open_bits[i]) begin
        res.idx = dfsrt_pkg::LANE_IW'(i);
      end
    end
  end

endmodule

FILE: src/dfsrt_merge.sv
// Lowest lane with a hit wins.
module dfsrt_merge (
  input  dfsrt_pkg::lane_res_t           lanes [dfsrt_pkg::NUM_LANES],
  output logic                           found,
  output logic [dfsrt_pkg::VID_W-1:0]    vertex
);

  always_comb begin
    found  = 1'b0;
    vertex = '0;
    for (int l = dfsrt_pkg::NUM_LANES - 1; l >= 0; l--) begin
      if (lanes[l].hit) begin
        found  = 1'b1;
        vertex = dfsrt_pkg::VID_W'(l * dfsrt_pkg::LANE_W)
               + dfsrt_pkg::VID_W'(lanes[l].idx);
      end
    end
  end

endmodule
